// ===== rtl/fttp_pkg.sv =====
// Shared types and constants for the file transfer packet parser.
// Has no dependencies; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package fttp_pkg;

  // Default configuration.
  localparam int NAME_BYTES_DEF = 256;
  localparam int SIZE_BITS_DEF  = 32;

  // Result queue geometry.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Control byte values.
  localparam logic [7:0] CTRL_START = 8'd1;
  localparam logic [7:0] CTRL_DATA  = 8'd2;
  localparam logic [7:0] CTRL_END   = 8'd3;

  // Field tags.
  localparam logic [7:0] TAG_SIZE = 8'd0;
  localparam logic [7:0] TAG_NAME = 8'd1;

  // Packet kinds.
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // Verdict status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_LEN     = 3'd3;
  localparam logic [2:0] ST_SIZE    = 3'd4;
  localparam logic [2:0] ST_NAME    = 3'd5;
  localparam logic [2:0] ST_LONG    = 3'd6;

  // Result kinds.
  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_VERDICT = 1'b1;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } pkt_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [1:0]  packet_kind;
    logic [2:0]  status;
    logic [31:0] size_value;
    logic [15:0] declared_length;
    logic        verdict_last;
  } res_t;

  // What the parse stage hands to the verdict stage for one byte.
  typedef struct packed {
    logic        clear;
    logic [2:0]  code;
    logic        name_fail;
    logic        cmp_en;
    logic [7:0]  in_byte;
    logic        emit;
    logic        verdict;
    logic [1:0]  kind;
    logic [31:0] size_value;
    logic [15:0] declared_length;
  } stage_t;

  // Up to two result words written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

// ===== rtl/file_transfer_packet_parser.sv =====
// Top level of the file transfer packet parser.
// Depends on fttp_pkg, fttp_parse, fttp_verdict and fttp_out_queue.
`timescale 1ns / 1ps

//  channel   | valid      | stall      | word type | carries
//  ----------+------------+------------+-----------+---------------------------------
//  packet in | pkt_valid  | pkt_stall  | pkt_t     | one packet byte and its last flag
//  result    | res_valid  | res_stall  | res_t     | a payload byte or a packet verdict
//
// One packet byte is taken every cycle while pkt_stall is low. The parse stage updates the field
// registers and issues the name store read on the edge that takes the byte;
// the verdict stage resolves the error code from that registered stage word, and its result
// words are registered into the result queue before they are offered. A byte that ends
// a data packet can yield two words; the four-entry result queue absorbs them and input
// stalls only while the queue holds more than two words. Reset is synchronous: control
// registers clear, the name store is not cleared because an end packet only reads bytes
// that a start packet has written.

module file_transfer_packet_parser import fttp_pkg::*; #(
  parameter int NAME_BYTES = NAME_BYTES_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic pkt_valid,
  output logic pkt_stall,
  input  pkt_t pkt_word,
  output logic res_valid,
  input  logic res_stall,
  output res_t res_word
);

  // Parse stage to verdict stage: one registered word per accepted byte,
  // plus the name store read data that lines up with it.
  logic       s2_valid;
  stage_t     s2;
  logic [7:0] name_rd;
  logic       s2_take;

  // Verdict stage to result queue.
  push_t push;
  logic  room;

  fttp_parse #(
    .NAME_BYTES (NAME_BYTES),
    .SIZE_BITS  (SIZE_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt_word  (pkt_word),
    .s2_valid  (s2_valid),
    .s2        (s2),
    .name_rd   (name_rd),
    .s2_take   (s2_take)
  );

  fttp_verdict u_verdict (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2       (s2),
    .name_rd  (name_rd),
    .room     (room),
    .s2_take  (s2_take),
    .push     (push)
  );

  fttp_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule

// ===== rtl/fttp_parse.sv =====
// Parse stage: byte-level state machine, field registers and the file name store.
// Depends on fttp_pkg.
`timescale 1ns / 1ps

module fttp_parse import fttp_pkg::*; #(
  parameter int NAME_BYTES = NAME_BYTES_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   pkt_valid,
  output logic   pkt_stall,
  input  pkt_t   pkt_word,
  output logic   s2_valid,
  output stage_t s2,
  output logic [7:0] name_rd,
  input  logic   s2_take
);

  localparam int LW = $clog2(NAME_BYTES + 1);
  localparam int AW = $clog2(NAME_BYTES);
  localparam logic [8:0] NB9 = 9'(NAME_BYTES);

  typedef enum logic [7:0] {
    PH_CTRL    = 8'b0000_0001,
    PH_TAG     = 8'b0000_0010,
    PH_LEN     = 8'b0000_0100,
    PH_VALUE   = 8'b0000_1000,
    PH_DHI     = 8'b0001_0000,
    PH_DLO     = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_SKIP    = 8'b1000_0000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [1:0]             ptype, ptype_next;
  logic [7:0]             field_tag, field_tag_next;
  logic [7:0]             field_rem, field_rem_next;
  logic [SIZE_BITS-1:0]   size_acc, size_acc_next;
  logic [SIZE_BITS-1:0]   stored_size, stored_size_next;
  logic [LW-1:0]          stored_len, stored_len_next;
  logic [7:0]             name_pos, name_pos_next;
  logic [15:0]            data_len, data_len_next;
  logic [16:0]            data_count, data_count_next;

  logic [7:0] name_mem [NAME_BYTES];

  logic   accept;
  logic   is_start;
  logic   finish;
  logic   mem_we;
  logic [2:0] code_tlv, code_last;
  stage_t s2_next;

  assign accept    = pkt_valid && (!s2_valid || s2_take);
  assign pkt_stall = s2_valid && !s2_take;
  assign is_start  = (ptype == KIND_START);

  always_comb begin
    phase_next       = phase;
    ptype_next       = ptype;
    field_tag_next   = field_tag;
    field_rem_next   = field_rem;
    size_acc_next    = size_acc;
    stored_size_next = stored_size;
    stored_len_next  = stored_len;
    name_pos_next    = name_pos;
    data_len_next    = data_len;
    data_count_next  = data_count;
    code_tlv         = ST_OK;
    code_last        = ST_OK;
    finish           = 1'b0;
    mem_we           = 1'b0;
    s2_next          = '0;
    s2_next.in_byte  = pkt_word.in_byte;
    s2_next.verdict  = pkt_word.last_byte;

    case (phase)
      PH_CTRL: begin
        s2_next.clear   = 1'b1;
        size_acc_next   = '0;
        data_len_next   = '0;
        data_count_next = '0;
        field_tag_next  = '0;
        field_rem_next  = '0;
        name_pos_next   = '0;
        if (pkt_word.in_byte == CTRL_START) begin
          ptype_next = KIND_START;
          phase_next = PH_TAG;
        end else if (pkt_word.in_byte == CTRL_END) begin
          ptype_next = KIND_END;
          phase_next = PH_TAG;
        end else if (pkt_word.in_byte == CTRL_DATA) begin
          ptype_next = KIND_DATA;
          phase_next = PH_DHI;
        end else begin
          ptype_next = KIND_UNKNOWN;
          phase_next = PH_SKIP;
          code_tlv   = ST_UNKNOWN;
        end
      end
      PH_DHI: begin
        data_len_next = {pkt_word.in_byte, 8'h00};
        phase_next    = PH_DLO;
      end
      PH_DLO: begin
        data_len_next = {data_len[15:8], pkt_word.in_byte};
        phase_next    = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        s2_next.emit = (data_count < {1'b0, data_len});
        if (data_count != COUNT_MAX) begin
          data_count_next = data_count + 17'd1;
        end
      end
      PH_SKIP: begin
        phase_next = PH_SKIP;
      end
      PH_TAG: begin
        field_tag_next = pkt_word.in_byte;
        phase_next     = PH_LEN;
      end
      PH_LEN: begin
        field_rem_next = pkt_word.in_byte;
        name_pos_next  = '0;
        if (field_tag == TAG_SIZE) begin
          size_acc_next = '0;
        end
        if (field_tag == TAG_NAME) begin
          if (is_start && ({1'b0, pkt_word.in_byte} > NB9)) begin
            code_tlv = ST_LONG;
          end
          if (!is_start && ({1'b0, pkt_word.in_byte} != 9'(stored_len))) begin
            code_tlv = ST_NAME;
          end
        end
        if (pkt_word.in_byte == 8'd0) begin
          finish = 1'b1;
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (field_tag == TAG_SIZE) begin
          size_acc_next = {size_acc[SIZE_BITS-9:0], pkt_word.in_byte};
        end else if (field_tag == TAG_NAME) begin
          if (is_start) begin
            mem_we = ({1'b0, name_pos} < NB9);
          end else if (({1'b0, name_pos} >= 9'(stored_len)) ||
                       ({1'b0, name_pos} >= NB9)) begin
            s2_next.name_fail = 1'b1;
          end else begin
            s2_next.cmp_en = 1'b1;
          end
        end
        name_pos_next  = name_pos + 8'd1;
        field_rem_next = field_rem - 8'd1;
        if (field_rem == 8'd1) begin
          finish = 1'b1;
        end
      end
      default: begin
        phase_next = PH_CTRL;
      end
    endcase

    // A completed field is stored (start) or checked against the store (end).
    if (finish) begin
      if (field_tag == TAG_SIZE) begin
        if (is_start) begin
          stored_size_next = size_acc_next;
        end else if (size_acc_next != stored_size) begin
          code_tlv = ST_SIZE;
        end
      end else if (field_tag == TAG_NAME && is_start) begin
        stored_len_next = ({1'b0, name_pos_next} > NB9) ? LW'(NAME_BYTES)
                                                        : LW'(name_pos_next);
      end
      phase_next = PH_TAG;
    end

    if (pkt_word.last_byte) begin
      s2_next.kind = ptype_next;
      if (ptype_next == KIND_START || ptype_next == KIND_END) begin
        if (phase_next != PH_TAG) begin
          code_last = ST_TRUNC;
        end
        s2_next.size_value = 32'(size_acc_next);
      end else if (ptype_next == KIND_DATA) begin
        if (phase_next == PH_DHI || phase_next == PH_DLO) begin
          code_last = ST_TRUNC;
        end else if (data_count_next != {1'b0, data_len_next}) begin
          code_last = ST_LEN;
        end
        s2_next.declared_length = data_len_next;
      end
      phase_next = PH_CTRL;
    end

    s2_next.code = (code_tlv != ST_OK) ? code_tlv : code_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_CTRL;
      ptype       <= KIND_START;
      field_tag   <= '0;
      field_rem   <= '0;
      size_acc    <= '0;
      stored_size <= '0;
      stored_len  <= '0;
      name_pos    <= '0;
      data_len    <= '0;
      data_count  <= '0;
      s2_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase       <= phase_next;
        ptype       <= ptype_next;
        field_tag   <= field_tag_next;
        field_rem   <= field_rem_next;
        size_acc    <= size_acc_next;
        stored_size <= stored_size_next;
        stored_len  <= stored_len_next;
        name_pos    <= name_pos_next;
        data_len    <= data_len_next;
        data_count  <= data_count_next;
        s2_valid    <= 1'b1;
      end else if (s2_take) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2 <= s2_next;
    end
  end

  // Name store: written by start packets, read in the parse stage ahead of the compare in the verdict stage.
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      name_mem[name_pos[AW-1:0]] <= pkt_word.in_byte;
    end
    if (accept && s2_next.cmp_en) begin
      name_rd <= name_mem[name_pos[AW-1:0]];
    end
  end

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    accept && pkt_word.last_byte |=> phase == PH_CTRL)
    else $error("phase did not return to control after a final byte");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    9'(stored_len) <= NB9)
    else $error("stored name length exceeds the store");

endmodule

// ===== rtl/fttp_verdict.sv =====
// Verdict stage: resolves the sticky error code and forms the result words.
// Depends on fttp_pkg.
`timescale 1ns / 1ps

module fttp_verdict import fttp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s2_valid,
  input  stage_t     s2,
  input  logic [7:0] name_rd,
  input  logic       room,
  output logic       s2_take,
  output push_t      push
);

  logic [2:0] error_code, error_next;
  logic       name_bad;
  res_t       pay_word, ver_word;

  assign s2_take  = s2_valid && room;
  assign name_bad = s2.name_fail || (s2.cmp_en && (name_rd != s2.in_byte));

  always_comb begin
    // The first error of a packet is kept; a name mismatch on this byte
    // ranks ahead of anything else the byte raises.
    error_next = s2.clear ? ST_OK : error_code;
    if (error_next == ST_OK && name_bad) begin
      error_next = ST_NAME;
    end
    if (error_next == ST_OK) begin
      error_next = s2.code;
    end

    pay_word                 = '0;
    pay_word.result_kind     = RES_PAYLOAD;
    pay_word.payload_byte    = s2.in_byte;
    pay_word.packet_kind     = KIND_DATA;
    pay_word.status          = ST_OK;
    pay_word.verdict_last    = !s2.verdict;

    ver_word                 = '0;
    ver_word.result_kind     = RES_VERDICT;
    ver_word.packet_kind     = s2.kind;
    ver_word.status          = error_next;
    ver_word.size_value      = s2.size_value;
    ver_word.declared_length = s2.declared_length;
    ver_word.verdict_last    = 1'b1;

    push        = '0;
    push.second = ver_word;
    if (s2.emit) begin
      push.first = pay_word;
      push.count = s2.verdict ? 2'd2 : 2'd1;
    end else if (s2.verdict) begin
      push.first = ver_word;
      push.count = 2'd1;
    end
    if (!s2_take) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_code <= ST_OK;
    end else if (s2_take) begin
      error_code <= error_next;
    end
  end

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    s2_take && !s2.clear && error_code != ST_OK |=> error_code == $past(error_code))
    else $error("error code changed within a packet after the first error");

endmodule

// ===== rtl/fttp_out_queue.sv =====
// Four-entry result queue between the verdict stage and the result port.
// Depends on fttp_pkg.
`timescale 1ns / 1ps

module fttp_out_queue import fttp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  res_valid,
  input  logic  res_stall,
  output res_t  res_word
);

  res_t             q [OQ_DEPTH];
  logic [OQ_AW-1:0] wp, rp;
  logic [OQ_CW-1:0] count;
  logic             pop;

  assign res_valid = (count != '0);
  assign res_word  = q[rp];
  assign pop       = res_valid && !res_stall;
  assign room      = (count <= OQ_CW'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wp] <= push.first;
    end
    if (push.count == 2'd2) begin
      q[wp + OQ_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + OQ_AW'(push.count);
      rp    <= rp + OQ_AW'(pop);
      count <= count + OQ_CW'(push.count) - OQ_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= OQ_CW'(OQ_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count <= OQ_CW'(OQ_DEPTH - 2))
    else $error("push into result queue without room for two words");

endmodule
